### src/dpu_pkg.sv
package dpu_pkg;

  // Field widths
  localparam int COORD_W = 12;
  localparam int DEPTH_W = 24;
  localparam int PP_W    = 21;
  localparam int INV_W   = 24;
  localparam int ROT_W   = 21;
  localparam int SHIFT_W = 24;
  localparam int POINT_W = 32;
  localparam int CAM_W   = 37;  // back-projected coordinate, Q.16
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_POINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_A       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_B       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_C       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z         = 3'd7;

  // Reset values: ppx 320.0, ppy 240.0, 1/f about 1/600, identity rotation
  localparam logic [41:0] PP_RESET    = 42'd128849100800;
  localparam logic [47:0] INV_RESET   = 48'd469124541754;
  localparam logic [62:0] ROT_A_RESET = 63'd262144;
  localparam logic [62:0] ROT_B_RESET = 63'd549755813888;
  localparam logic [62:0] ROT_C_RESET = 63'd1152921504606846976;

  // Load enables for the back-projection stages of one axis
  typedef struct packed {
    logic dx;
    logic prod;
    logic part;
    logic proj;
  } axis_en_t;

  // Load enables for the transform stages of one output row
  typedef struct packed {
    logic mul;
    logic sum;
  } row_en_t;

endpackage

### src/dpu_axis.sv
// Back-projection of one image axis: round((coord*256 - pp) * z * inv / 2^32)
module dpu_axis (
  input  logic                                 clk,
  input  dpu_pkg::axis_en_t                    en,
  input  logic        [dpu_pkg::COORD_W-1:0]   coord,
  input  logic signed [dpu_pkg::DEPTH_W-1:0]   depth,
  input  logic        [dpu_pkg::PP_W-1:0]      pp,
  input  logic        [dpu_pkg::INV_W-1:0]     inv,
  output logic signed [dpu_pkg::CAM_W-1:0]     cam
);

  logic signed [21:0] dx;
  logic signed [21:0] dx_next;
  logic signed [23:0] depth_d;
  logic signed [45:0] prod;
  logic signed [45:0] prod_next;
  logic signed [58:0] part_hi;
  logic signed [58:0] part_lo;
  logic signed [58:0] part_hi_next;
  logic signed [58:0] part_lo_next;
  logic signed [58:0] lo_rnd;
  logic signed [58:0] lo_sh;
  logic signed [58:0] total;

  // Offset from the principal point, exact in Q.8
  assign dx_next = $signed({2'b00, coord, 8'h00}) - $signed({1'b0, pp});

  // Exact product in Q.24
  assign prod_next = 46'(dx) * 46'(depth_d);

  // Split the reciprocal so each multiplier stays narrow
  assign part_hi_next = 59'(prod) * $signed({47'd0, inv[23:12]});
  assign part_lo_next = 59'(prod) * $signed({47'd0, inv[11:0]});

  // Round to nearest, ties toward plus infinity
  assign lo_rnd = part_lo + (59'sd1 <<< 31);
  assign lo_sh  = lo_rnd >>> 12;
  assign total  = part_hi + lo_sh;

  always_ff @(posedge clk) begin
    if (en.dx) begin
      dx      <= dx_next;
      depth_d <= depth;
    end
    if (en.prod) begin
      prod <= prod_next;
    end
    if (en.part) begin
      part_hi <= part_hi_next;
      part_lo <= part_lo_next;
    end
    if (en.proj) begin
      cam <= total[56:20];
    end
  end

endmodule

### src/dpu_xform_row.sv
// One row of the rigid transform: r0*x + r1*y + r2*z + t, rounded and saturated
module dpu_xform_row (
  input  logic                                 clk,
  input  dpu_pkg::row_en_t                     en,
  input  logic signed [dpu_pkg::CAM_W-1:0]     cam_x,
  input  logic signed [dpu_pkg::CAM_W-1:0]     cam_y,
  input  logic signed [dpu_pkg::DEPTH_W-1:0]   cam_z,
  input  logic        [3*dpu_pkg::ROT_W-1:0]   row,
  input  logic        [dpu_pkg::SHIFT_W-1:0]   shift,
  output logic signed [dpu_pkg::POINT_W-1:0]   point
);

  logic signed [20:0] r0;
  logic signed [20:0] r1;
  logic signed [20:0] r2;
  logic signed [57:0] m0;
  logic signed [57:0] m1;
  logic signed [57:0] m2;
  logic signed [60:0] acc;
  logic signed [42:0] rnd;
  logic signed [31:0] point_next;

  assign r0 = $signed(row[20:0]);
  assign r1 = $signed(row[41:21]);
  assign r2 = $signed(row[62:42]);

  // Sum in Q.34, translation lifted from Q.16
  assign acc = 61'(m0) + 61'(m1) + 61'(m2)
             + (61'($signed(shift)) <<< 18) + (61'sd1 <<< 17);
  assign rnd = 43'(acc >>> 18);

  always_comb begin
    priority if (rnd > 43'sd2147483647) begin
      point_next = 32'sh7fffffff;
    end else if (rnd < -43'sd2147483648) begin
      point_next = 32'sh80000000;
    end else begin
      point_next = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      m0 <= 58'(r0) * 58'(cam_x);
      m1 <= 58'(r1) * 58'(cam_y);
      m2 <= 58'(r2) * 58'(cam_z);
    end
    if (en.sum) begin
      point <= point_next;
    end
  end

endmodule

### src/depth_pixel_unprojection_core.sv
// Depth pixel unprojection. Each request on the slave side is one depth pixel
// (column, row, signed Q8.16 depth). Pixels with a depth of zero or less, or
// outside MAX_COLUMNS x MAX_ROWS, are taken and dropped. Every other pixel is
// back-projected through the pinhole model held in the configuration registers
// and moved by the rigid transform [R|t]; the master side then carries the
// point in signed Q16.16 metres (rounded, saturated) with the source column
// and row. The block takes one pixel every clock while the master side
// accepts points: seven register stages (input, offset, depth product,
// reciprocal partial products, rounding, rotation products, sum and
// saturate) each hold one pixel. A stall on the master side backs up
// through the stage valid bits and never drops or repeats a pixel.
// Write configuration only while the pipeline is empty.
module depth_pixel_unprojection_core #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [dpu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpu_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Pixel stream in
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [47:0]                       s_tdata,  // pixel_col, pixel_line, depth_sample
  // Point stream out
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [119:0]                      m_tdata   // point_x, point_y, point_z, src_col, src_line
);

  localparam int NSTG = 7;

  // Configuration registers
  logic [41:0] pp;
  logic [47:0] inv;
  logic [62:0] rot_a;
  logic [62:0] rot_b;
  logic [62:0] rot_c;
  logic [23:0] shift_x;
  logic [23:0] shift_y;
  logic [23:0] shift_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp      <= dpu_pkg::PP_RESET;
      inv     <= dpu_pkg::INV_RESET;
      rot_a   <= dpu_pkg::ROT_A_RESET;
      rot_b   <= dpu_pkg::ROT_B_RESET;
      rot_c   <= dpu_pkg::ROT_C_RESET;
      shift_x <= '0;
      shift_y <= '0;
      shift_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpu_pkg::CFG_PRINCIPAL_POINT: pp      <= cfg_data[41:0];
        dpu_pkg::CFG_INV_FOCAL:       inv     <= cfg_data[47:0];
        dpu_pkg::CFG_ROT_ROW_A:       rot_a   <= cfg_data[62:0];
        dpu_pkg::CFG_ROT_ROW_B:       rot_b   <= cfg_data[62:0];
        dpu_pkg::CFG_ROT_ROW_C:       rot_c   <= cfg_data[62:0];
        dpu_pkg::CFG_SHIFT_X:         shift_x <= cfg_data[23:0];
        dpu_pkg::CFG_SHIFT_Y:         shift_y <= cfg_data[23:0];
        dpu_pkg::CFG_SHIFT_Z:         shift_z <= cfg_data[23:0];
      endcase
    end
  end

  // Unpack the request
  logic        [11:0] in_col;
  logic        [11:0] in_line;
  logic signed [23:0] in_depth;
  logic               in_keep;

  assign in_col   = s_tdata[11:0];
  assign in_line  = s_tdata[23:12];
  assign in_depth = $signed(s_tdata[47:24]);

  // Drop non-positive depth and pixels outside the image
  assign in_keep = !in_depth[23] && (in_depth != 24'sd0)
                && (32'(in_col) < 32'(MAX_COLUMNS))
                && (32'(in_line) < 32'(MAX_ROWS));

  // Stage control: a stage loads when empty or when the next one moves
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || m_tready;
    for (int i = NSTG-2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid && in_keep;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Side band carried along the pipe: coordinates to the end, depth to the
  // rotation products
  logic        [11:0] col_s   [NSTG];
  logic        [11:0] line_s  [NSTG];
  logic signed [23:0] depth_s [5];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      col_s[0]   <= in_col;
      line_s[0]  <= in_line;
      depth_s[0] <= in_depth;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) begin
        col_s[i]  <= col_s[i-1];
        line_s[i] <= line_s[i-1];
      end
    end
    for (int i = 1; i < 5; i++) begin
      if (en[i]) begin
        depth_s[i] <= depth_s[i-1];
      end
    end
  end

  // Back-projection, stages one to four
  dpu_pkg::axis_en_t axis_en;
  logic signed [dpu_pkg::CAM_W-1:0] cam_x;
  logic signed [dpu_pkg::CAM_W-1:0] cam_y;

  assign axis_en.dx   = en[1];
  assign axis_en.prod = en[2];
  assign axis_en.part = en[3];
  assign axis_en.proj = en[4];

  dpu_axis u_axis_x (
    .clk   (clk),
    .en    (axis_en),
    .coord (col_s[0]),
    .depth (depth_s[0]),
    .pp    (pp[20:0]),
    .inv   (inv[23:0]),
    .cam   (cam_x)
  );

  dpu_axis u_axis_y (
    .clk   (clk),
    .en    (axis_en),
    .coord (line_s[0]),
    .depth (depth_s[0]),
    .pp    (pp[41:21]),
    .inv   (inv[47:24]),
    .cam   (cam_y)
  );

  // Rigid transform, stages five and six
  dpu_pkg::row_en_t row_en;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  assign row_en.mul = en[5];
  assign row_en.sum = en[6];

  dpu_xform_row u_row_x (
    .clk   (clk),
    .en    (row_en),
    .cam_x (cam_x),
    .cam_y (cam_y),
    .cam_z (depth_s[4]),
    .row   (rot_a),
    .shift (shift_x),
    .point (point_x)
  );

  dpu_xform_row u_row_y (
    .clk   (clk),
    .en    (row_en),
    .cam_x (cam_x),
    .cam_y (cam_y),
    .cam_z (depth_s[4]),
    .row   (rot_b),
    .shift (shift_y),
    .point (point_y)
  );

  dpu_xform_row u_row_z (
    .clk   (clk),
    .en    (row_en),
    .cam_x (cam_x),
    .cam_y (cam_y),
    .cam_z (depth_s[4]),
    .row   (rot_c),
    .shift (shift_z),
    .point (point_z)
  );

  // Result request
  assign m_tvalid = vld[NSTG-1];
  assign m_tdata  = {line_s[NSTG-1], col_s[NSTG-1], point_z, point_y, point_x};

endmodule
